// ===== rtl/sha_pkg.sv =====
// Package for the SHA-256 digest engine: round constants, initial hash values,
// round functions and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 64;
    localparam logic [7:0]  PadByte  = 8'h80;

    typedef struct packed {
        logic       put_byte;
        logic       pad_sel;
        logic       count_byte;
        logic       start;
        logic       round;
        logic [5:0] round_idx;
        logic       finish;
        logic       write_len;
        logic       restart;
        logic [2:0] out_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } sha_stat_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, message_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256_digest.sv =====
// Streaming SHA-256 engine: one message byte per input beat, eight digest
// words per message. Usage:
//   msg channel: message_byte with byte_present; end_of_message closes the
//   message (byte_present=0 with end_of_message=1 is an empty end marker).
//   digest channel: eight beats, word_index 0..7, last_word on the eighth.
// Input: a byte beat is taken only while the engine is idle; the beat that
// fills a 64-byte block is followed by a busy compression (load, 64 rounds
// of the one round unit, chain update) before the next beat is taken.
// End of message: a pad step, an extra compression when 8 or fewer byte
// slots remained before the pad byte, a length step, a final compression,
// then the digest.
// The digest waits while the receiver stalls; no input is taken until all
// eight words are delivered, after which the engine is back at the initial
// hash values. Reset returns to the initial hash values, empty message.
// Depends on sha_pkg, sha_if, sha_ctrl, sha_dp.
`timescale 1ns / 1ps
`default_nettype none
module sha256_digest
    import sha_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source digest
);

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] word;

    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (msg.valid),
        .byte_present   (msg.byte_present),
        .end_of_message (msg.end_of_message),
        .in_ready       (msg.ready),
        .out_valid      (digest.valid),
        .out_ready      (digest.ready),
        .cmd            (cmd),
        .stat           (stat)
    );

    sha_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_byte (msg.message_byte),
        .stat    (stat),
        .digest  (word)
    );

    assign digest.digest_word = word;
    assign digest.word_index  = cmd.out_idx;
    assign digest.last_word   = (cmd.out_idx == 3'd7);

endmodule
`default_nettype wire

// ===== rtl/sha_dp.sv =====
// Datapath of the SHA-256 engine: block buffer, schedule window, working
// variables, chain words and bit count. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_dp
    import sha_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  sha_cmd_t          cmd,
    input  wire  [7:0]        in_byte,
    output sha_stat_t         stat,
    output logic [31:0]       digest
);

    logic [31:0] block_reg [BlkWords];
    logic [31:0] win_reg   [BlkWords];
    logic [31:0] var_reg   [8];
    logic [31:0] chain_reg [8];
    logic [63:0] count_reg;
    logic [5:0]  pos_reg;

    logic [7:0]  byte_val;
    logic [31:0] w_new, t1, t2;

    assign byte_val = cmd.pad_sel ? PadByte : in_byte;
    assign w_new = sml_s1(win_reg[14]) + win_reg[9] + sml_s0(win_reg[1]) + win_reg[0];
    assign t1 = var_reg[7] + big_s1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + round_k(cmd.round_idx) + win_reg[0];
    assign t2 = big_s0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    assign stat.pos = pos_reg;
    assign digest   = chain_reg[cmd.out_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
            for (int i = 0; i < BlkWords; i++)
            begin
                block_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.count_byte)
            begin
                count_reg <= count_reg + 64'd8;
            end
            if (cmd.put_byte)
            begin
                for (int i = 0; i < BlkWords; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (pos_reg == 6'(i * 4 + j))
                        begin
                            block_reg[i][(3 - j) * 8 +: 8] <= byte_val;
                        end
                    end
                end
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.write_len)
            begin
                block_reg[14] <= count_reg[63:32];
                block_reg[15] <= count_reg[31:0];
            end
            if (cmd.start)
            begin
                pos_reg <= '0;
                for (int i = 0; i < BlkWords; i++)
                begin
                    block_reg[i] <= '0;
                end
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (cmd.restart)
            begin
                count_reg <= '0;
                pos_reg   <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= init_hash(3'(i));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < BlkWords; i++)
            begin
                win_reg[i] <= block_reg[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < BlkWords - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BlkWords - 1] <= w_new;
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// Controller of the SHA-256 engine: sequences byte loads, padding, rounds
// and digest output. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        byte_present,
    input  wire        end_of_message,
    output logic       in_ready,
    output logic       out_valid,
    input  wire        out_ready,
    output sha_cmd_t   cmd,
    input  sha_stat_t  stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_fire, out_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.put_byte   = byte_present;
                    cmd.count_byte = byte_present;
                    if (byte_present && stat.pos == 6'd63)
                    begin
                        state_next = S_START;
                        ret_next   = end_of_message ? S_PAD : S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.put_byte = 1'b1;
                cmd.pad_sel  = 1'b1;
                if (stat.pos >= 6'd56)
                begin
                    state_next = S_START;
                    ret_next   = S_LEN;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.write_len = 1'b1;
                state_next    = S_START;
                ret_next      = S_OUT;
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                rnd_next   = '0;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'(Rounds - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                idx_next   = '0;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input open while digest pending");
    a_round_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> !in_ready) else $error("input open during rounds");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && idx_reg == 3'd7) |=> (in_ready && idx_reg == 3'd0))
        else $error("engine not idle after last word");
    a_fin_after_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> $past(cmd.round)) else $error("finish without rounds");
`endif

endmodule
`default_nettype wire

// ===== sim/sha256_digest_test.sv =====
// Testbench for sha256_digest: drives message bytes with random gaps and checks
// every digest word against a SHA-256 predictor held in a scoreboard class.
// Depends on sha_pkg, sha_if and the sha256_digest RTL.
`timescale 1ns / 1ps
`default_nettype none

class digest_scoreboard;
    logic [31:0] chain[8];
    logic [31:0] block[16];
    logic [63:0] bit_count;
    int          pos;
    logic [31:0] exp_word[$];
    logic [2:0]  exp_index[$];
    logic        exp_last[$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
        chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
        chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
        chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
        foreach (block[i]) block[i] = '0;
        bit_count = '0;
        pos = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function logic [31:0] kconst(int t);
        logic [31:0] k[64];
        k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
              32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
              32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
              32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
              32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
              32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
              32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
              32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
              32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
              32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
              32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
              32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
              32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = block[t];
            else
                w[t] = w[t-16] + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                     + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        foreach (v[i]) v[i] = chain[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        foreach (chain[i]) chain[i] += v[i];
        foreach (block[i]) block[i] = '0;
        pos = 0;
    endfunction

    function void add_byte(logic [7:0] b);
        block[pos / 4] |= 32'(b) << (24 - 8 * (pos % 4));
        pos++;
        if (pos == 64)
            compress();
    endfunction

    function void note_beat(logic [7:0] b, logic present, logic eom);
        logic [63:0] bits;
        if (present)
        begin
            add_byte(b);
            bit_count += 64'd8;
        end
        if (!eom)
            return;
        bits = bit_count;
        add_byte(sha_pkg::PadByte);
        if (pos > 56)
            compress();
        block[14] = bits[63:32];
        block[15] = bits[31:0];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            exp_word.push_back(chain[i]);
            exp_index.push_back(3'(i));
            exp_last.push_back(i == 7);
        end
        restart();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_beat(logic [31:0] word, logic [2:0] idx, logic last);
        logic [31:0] w;
        logic [2:0]  x;
        logic        l;
        if (exp_word.size() == 0)
        begin
            report("unexpected digest beat", word, 32'd0);
            return;
        end
        w = exp_word.pop_front();
        x = exp_index.pop_front();
        l = exp_last.pop_front();
        if (word !== w) report("digest_word", word, w);
        if (idx !== x) report("word_index", 32'(idx), 32'(x));
        if (last !== l) report("last_word", 32'(last), 32'(l));
    endtask

    function int pending();
        return exp_word.size();
    endfunction
endclass

module sha256_digest_test;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    sha_in_if  msg();
    sha_out_if digest();
    digest_scoreboard sb = new();
    int  idle_pct = 38;
    int  beats = 0;
    bit  hold_off = 1'b0;

    sha256_digest dut (.clk(clk), .rst_n(rst_n), .msg(msg.sink), .digest(digest.source));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        msg.valid = 1'b0;
        msg.message_byte = '0;
        msg.byte_present = 1'b0;
        msg.end_of_message = 1'b0;
        digest.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (msg.valid && msg.ready)
            sb.note_beat(msg.message_byte, msg.byte_present, msg.end_of_message);
        if (digest.valid && digest.ready)
            sb.check_beat(digest.digest_word, digest.word_index, digest.last_word);
    end

    always @(posedge clk)
        digest.ready <= !hold_off && ($urandom_range(99) >= idle_pct);

    task automatic send_beat(logic [7:0] b, logic present, logic eom);
        while ($urandom_range(99) < idle_pct)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid <= 1'b1;
        msg.message_byte <= b;
        msg.byte_present <= present;
        msg.end_of_message <= eom;
        do @(posedge clk); while (!msg.ready);
        beats++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
        end
        if (len == 0 || !msg.end_of_message)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        msg.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, extreme bytes, padding edges
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        drain();
        idle_pct = 0;
        send_message(55);
        send_message(56);
        send_message(64);
        drain();
        // hold off the receiver while bytes keep coming
        fork
        begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
        end
        begin
            send_message(3);
            send_message(2);
        end
        join
        drain();
        idle_pct = 38;
        while (beats < 300)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(65, 90) : $urandom_range(0, 20);
            send_message(len);
        end
        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** sha256_digest: PASSED **");
        else
            $display("** sha256_digest: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** sha256_digest: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_dp.sv
rtl/sha_ctrl.sv
rtl/sha256_digest.sv
sim/sha256_digest_test.sv
